// ----- src/sqpd_pkg.sv -----
`default_nettype none
package sqpd_pkg;
  localparam int ExpBits = 6;
  localparam int SecPerDay = 86400;

  typedef struct packed {
    logic        climate_present;
    logic        power_present;
    logic [14:0] raw_temp;
    logic        temp_invalid;
    logic [14:0] raw_hum;
    logic        hum_invalid;
    logic [14:0] raw_volt;
    logic [12:0] raw_current;
    logic [31:0] now_seconds;
    logic        time_valid;
  } in_item_t;

  typedef struct packed {
    logic [14:0] temp_out;
    logic [13:0] hum_out;
    logic [14:0] volt_out;
    logic [14:0] amp_out;
    logic [18:0] watt_out;
    logic [17:0] peak_out;
    logic [1:0]  error_bits;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_TEMP_OFFSET = 3'd0,
    REG_HUM_OFFSET  = 3'd1,
    REG_GAIN        = 3'd2,
    REG_FLOOR       = 3'd3,
    REG_INITIAL     = 3'd4,
    REG_HALFLIFE    = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_AMP, CMD_PROD, CMD_WATT, CMD_DIV, CMD_EXP, CMD_SCALE,
    CMD_TRACK
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } dp_ctrl_t;

  typedef struct packed {
    logic step_done;
    logic need_decay;
  } dp_stat_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    begin
      v = x;
      res = '0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    end
  endfunction

  localparam logic [63:0] ExpC1  = isqrt64(64'd1 << 59);
  localparam logic [63:0] ExpC2  = isqrt64(ExpC1 << 30);
  localparam logic [63:0] ExpC3  = isqrt64(ExpC2 << 30);
  localparam logic [63:0] ExpC4  = isqrt64(ExpC3 << 30);
  localparam logic [63:0] ExpC5  = isqrt64(ExpC4 << 30);
  localparam logic [63:0] ExpC6  = isqrt64(ExpC5 << 30);
  localparam logic [63:0] ExpC7  = isqrt64(ExpC6 << 30);
  localparam logic [63:0] ExpC8  = isqrt64(ExpC7 << 30);
  localparam logic [63:0] ExpC9  = isqrt64(ExpC8 << 30);
  localparam logic [63:0] ExpC10 = isqrt64(ExpC9 << 30);

  // q30 constants 2^(-2^-k), k = 1..ExpBits
  function automatic logic [30:0] exp_const(input int k);
    logic [30:0] c;
    begin
      c = 31'd0;
      case (k)
        1:  c = ExpC1[30:0];
        2:  c = ExpC2[30:0];
        3:  c = ExpC3[30:0];
        4:  c = ExpC4[30:0];
        5:  c = ExpC5[30:0];
        6:  c = ExpC6[30:0];
        7:  c = ExpC7[30:0];
        8:  c = ExpC8[30:0];
        9:  c = ExpC9[30:0];
        10: c = ExpC10[30:0];
        default: c = 31'd1073741824;
      endcase
      return c;
    end
  endfunction
endpackage
`default_nettype wire

// ----- src/sqpd_if.sv -----
`default_nettype none
interface sqpd_in_if;
  import sqpd_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sqpd_out_if;
  import sqpd_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/sensor_qualify_peak_decay.sv -----
`default_nettype none
// Qualifies one climate and power reading per item and tracks a decaying peak
// power. When the peak decays, an item also passes through the 38-step
// restoring divider for elapsed time over the half-life, the 6-step exponent
// multiply loop and one scaling step before its result can be taken. The result
// register holds until taken, and the next item is accepted in the same cycle.
module sensor_qualify_peak_decay (
  input  wire logic        clk,
  input  wire logic        rst,
  sqpd_in_if.sink          in_ch,
  sqpd_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [17:0] cfg_data
);
  import sqpd_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  sqpd_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .ctrl(ctrl), .stat(stat)
  );

  sqpd_dp u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat), .item(in_ch.data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .result(out_ch.data)
  );
endmodule
`default_nettype wire

// ----- src/sqpd_ctrl.sv -----
`default_nettype none
module sqpd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sqpd_pkg::dp_ctrl_t      ctrl,
  input  wire sqpd_pkg::dp_stat_t stat
);
  import sqpd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_AMP, S_PROD, S_WATT, S_DIV, S_EXP, S_SCALE, S_TRACK, S_OUT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);

  always_comb begin
    ctrl.cmd = CMD_NONE;
    unique case (state)
      S_IDLE:  if (in_valid) ctrl.cmd = CMD_LOAD;
      S_AMP:   ctrl.cmd = CMD_AMP;
      S_PROD:  ctrl.cmd = CMD_PROD;
      S_WATT:  ctrl.cmd = CMD_WATT;
      S_DIV:   ctrl.cmd = CMD_DIV;
      S_EXP:   ctrl.cmd = CMD_EXP;
      S_SCALE: ctrl.cmd = CMD_SCALE;
      S_TRACK: ctrl.cmd = CMD_TRACK;
      S_OUT:   if (out_ready && in_valid) ctrl.cmd = CMD_LOAD;
      default: ctrl.cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_AMP;
        S_AMP: state <= S_PROD;
        S_PROD: state <= S_WATT;
        S_WATT: state <= stat.need_decay ? S_DIV : S_TRACK;
        S_DIV: if (stat.step_done) state <= S_EXP;
        S_EXP: if (stat.step_done) state <= S_SCALE;
        S_SCALE: if (stat.step_done) state <= S_TRACK;
        S_TRACK: begin
          state     <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state     <= in_valid ? S_AMP : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- src/sqpd_dp.sv -----
`default_nettype none
module sqpd_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sqpd_pkg::dp_ctrl_t  ctrl,
  output sqpd_pkg::dp_stat_t       stat,
  input  wire sqpd_pkg::in_item_t  item,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_idx,
  input  wire logic [17:0]         cfg_data,
  output sqpd_pkg::out_item_t      result
);
  import sqpd_pkg::*;

  localparam int DivW = 32 + ExpBits;
  localparam int CntW = $clog2(DivW + 1);
  // ceil(2^39 / 1000), exact for dividends below 2^29
  localparam logic [29:0] Recip1000 = 30'd549755814;

  logic signed [10:0] temp_offset;
  logic signed [11:0] hum_offset;
  logic [10:0] current_gain;
  logic [17:0] peak_floor;
  logic [8:0]  halflife_days;

  logic signed [15:0] temp_held;
  logic [13:0] hum_held;
  logic [14:0] volt_held;
  logic signed [14:0] amp_held;
  logic signed [18:0] watt_held;
  logic [17:0] peak_record, peak_shown;
  logic [31:0] peak_stamp;
  logic [1:0]  error_held;

  in_item_t    cur;
  logic        pwr_track;
  logic [14:0] amag_r;
  logic [28:0] qprod;
  logic [31:0] dvsr;
  logic [DivW-1:0] quo;
  logic [31:0] rem;
  logic [CntW-1:0] cnt;
  logic [30:0] mfac;
  logic [17:0] eff;

  logic signed [23:0] p;
  logic [23:0] pmag;
  logic [15:0] amag;
  logic [14:0] asat;
  logic [28:0] qmag;
  logic [58:0] wprod;
  logic [18:0] wq;
  logic [18:0] wsat;
  logic [18:0] wnew;
  logic [32:0] rsh;
  logic [61:0] mprod;
  logic [48:0] sprod;
  logic [31:0] scaled;
  logic [31:0] nq;
  logic [ExpBits-1:0] fq;
  logic signed [16:0] hsum;
  logic clim_ok, volt_in;
  logic [31:0] elapsed;

  assign p = 24'(signed'(cur.raw_current)) * signed'({13'd0, current_gain});
  assign pmag = p[23] ? 24'(-p) : p;
  assign amag = 16'((pmag + 24'd128) >> 8);
  assign asat = (amag > 16'd12800) ? 15'd12800 : amag[14:0];
  assign qmag = 29'(cur.raw_volt) * 29'(amag_r);
  assign wprod = 59'(qprod) * 59'(Recip1000);
  assign wq = 19'(wprod >> 39);
  assign wsat = (wq > 19'd192000) ? 19'd192000 : wq;
  assign wnew = p[23] ? 19'(-wsat) : wsat;
  assign elapsed = cur.now_seconds - peak_stamp;
  assign rsh = {rem, quo[DivW-1]};
  assign nq = quo[DivW-1:ExpBits];
  assign fq = quo[ExpBits-1:0];
  assign mprod = 62'(mfac) * 62'(exp_const(int'(cnt) + 1));
  assign sprod = 49'(peak_record) * 49'(mfac);
  assign scaled = 32'(sprod >> 30) >> nq[4:0];
  assign hsum = 17'(signed'(cur.raw_hum)) + 17'(hum_offset);
  assign clim_ok = cur.climate_present && !cur.temp_invalid && !cur.hum_invalid
    && (signed'(cur.raw_temp) >= -15'sd2000) && (signed'(cur.raw_temp) <= 15'sd8000)
    && (signed'(cur.raw_hum) >= 15'sd0) && (signed'(cur.raw_hum) <= 15'sd10000);
  assign volt_in = (cur.raw_volt >= 15'd8000) && (cur.raw_volt <= 15'd15000);

  always_comb begin
    stat.need_decay = pwr_track && !wnew[18] && (wnew[17:0] >= peak_floor)
      && cur.time_valid && peak_stamp != 32'd0
      && cur.now_seconds > peak_stamp;
    stat.step_done = 1'b0;
    case (ctrl.cmd)
      CMD_DIV:   stat.step_done = (cnt == CntW'(DivW - 1));
      CMD_EXP:   stat.step_done = (cnt == CntW'(ExpBits - 1));
      CMD_SCALE: stat.step_done = 1'b1;
      default:   stat.step_done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_offset <= '0;
      hum_offset <= '0;
      current_gain <= 11'd256;
      peak_floor <= 18'd1000;
      halflife_days <= 9'd30;
      temp_held <= '0;
      hum_held <= '0;
      volt_held <= '0;
      amp_held <= '0;
      watt_held <= '0;
      peak_record <= 18'd10000;
      peak_shown <= 18'd10000;
      peak_stamp <= '0;
      error_held <= '0;
      pwr_track <= 1'b0;
      cnt <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_TEMP_OFFSET: temp_offset <= cfg_data[10:0];
          REG_HUM_OFFSET:  hum_offset <= cfg_data[11:0];
          REG_GAIN:        current_gain <= cfg_data[10:0];
          REG_FLOOR:       peak_floor <= cfg_data;
          REG_INITIAL:     ;
          REG_HALFLIFE:    halflife_days <= cfg_data[8:0];
          default: ;
        endcase
      end
      case (ctrl.cmd)
        CMD_LOAD: begin
          cur <= item;
          pwr_track <= 1'b0;
        end
        CMD_AMP: begin
          if (!cur.climate_present || !clim_ok) error_held[0] <= 1'b1;
          else begin
            temp_held <= 16'(signed'(cur.raw_temp)) + 16'(temp_offset);
            hum_held <= hsum[16] ? 14'd0 : (hsum > 17'sd10000) ? 14'd10000 : hsum[13:0];
            error_held[0] <= 1'b0;
          end
          if (!cur.power_present) error_held[1] <= 1'b1;
          else begin
            volt_held <= cur.raw_volt;
            error_held[1] <= 1'b0;
            if (!volt_in) begin
              amp_held <= '0;
              watt_held <= '0;
            end else begin
              amp_held <= p[23] ? 15'(-asat) : asat;
              amag_r <= asat;
              pwr_track <= 1'b1;
            end
          end
        end
        CMD_PROD: qprod <= qmag + 29'd500;
        CMD_WATT: begin
          if (pwr_track) watt_held <= wnew;
          dvsr <= 32'(SecPerDay) * ((halflife_days == 9'd0) ? 32'd1 : 32'(halflife_days));
          quo <= {elapsed, ExpBits'(0)};
          rem <= '0;
          cnt <= '0;
          mfac <= 31'd1073741824;
          eff <= peak_record;
        end
        CMD_DIV: begin
          if (rsh >= 33'(dvsr)) begin
            rem <= 32'(rsh - 33'(dvsr));
            quo <= {quo[DivW-2:0], 1'b1};
          end else begin
            rem <= rsh[31:0];
            quo <= {quo[DivW-2:0], 1'b0};
          end
          cnt <= (cnt == CntW'(DivW - 1)) ? '0 : cnt + 1'b1;
        end
        CMD_EXP: begin
          if (fq[ExpBits - 1 - int'(cnt)])
            mfac <= 31'((mprod + 62'(1 << 29)) >> 30);
          cnt <= (cnt == CntW'(ExpBits - 1)) ? '0 : cnt + 1'b1;
        end
        CMD_SCALE: eff <= (nq >= 32'd32) ? 18'd0 : scaled[17:0];
        CMD_TRACK: begin
          if (pwr_track && !watt_held[18] && 18'(watt_held) >= peak_floor) begin
            if (18'(watt_held) > ((eff < peak_floor) ? peak_floor : eff)) begin
              peak_record <= 18'(watt_held);
              peak_stamp <= cur.time_valid ? cur.now_seconds : 32'd0;
              peak_shown <= 18'(watt_held);
            end else begin
              peak_shown <= (eff < peak_floor) ? peak_floor : eff;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign result.temp_out = temp_held[14:0];
  assign result.hum_out = hum_held;
  assign result.volt_out = volt_held;
  assign result.amp_out = amp_held;
  assign result.watt_out = watt_held;
  assign result.peak_out = peak_shown;
  assign result.error_bits = error_held;
endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none
module testbench;
  import sqpd_pkg::*;

  localparam int StallLimit = 3000;
  localparam int SettleCycles = 80;

  typedef struct {
    in_item_t   item;
    bit         typed;
    out_item_t  want;
  } row_t;

  typedef struct {
    bit         typed;
    out_item_t  want;
  } note_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [17:0] cfg_data;

  sqpd_in_if  in_ch ();
  sqpd_out_if out_ch ();

  sensor_qualify_peak_decay dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // predictor copy of the configuration and held state
  longint          p_temp_off;
  longint          p_hum_off;
  longint unsigned p_gain;
  longint unsigned p_floor;
  longint unsigned p_halflife;
  longint          temp_held;
  longint          hum_held;
  longint          volt_held;
  longint          amp_held;
  longint          watt_held;
  longint unsigned peak_record;
  longint unsigned peak_stamp;
  longint unsigned peak_shown;
  bit [1:0]        error_held;

  out_item_t readings_due[$];
  note_t     typed_due[$];
  row_t      table_rows[$];

  int  mismatches;
  int  sent;
  int  taken_in;
  int  taken_out;
  int  quiet;
  int  stall_left;
  bit  burst;
  int  decays_seen;
  longint unsigned wall;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned decayed_peak(longint unsigned elapsed);
    longint unsigned span;
    longint unsigned whole;
    longint unsigned frac;
    longint unsigned factor;
    longint unsigned c;
    span = 64'd86400 * ((p_halflife == 0) ? 64'd1 : p_halflife);
    whole = elapsed / span;
    frac = ((elapsed % span) << ExpBits) / span;
    factor = 64'd1 << 30;
    c = 64'd1 << 29;
    for (int k = 1; k <= ExpBits; k++) begin
      c = int_sqrt(c << 30);
      if (frac[ExpBits - k]) factor = (factor * c + (64'd1 << 29)) >> 30;
    end
    if (whole >= 32) return 0;
    return ((peak_record * factor) >> 30) >> whole;
  endfunction

  function automatic out_item_t qualify_reading(in_item_t x);
    longint          rt;
    longint          rh;
    longint          rc;
    longint          rv;
    longint          h;
    longint          prod;
    longint          amp;
    longint          pw;
    longint          watt;
    longint unsigned now;
    longint unsigned eff;
    out_item_t       r;
    rt = longint'($signed(x.raw_temp));
    rh = longint'($signed(x.raw_hum));
    rc = longint'($signed(x.raw_current));
    rv = longint'(x.raw_volt);
    now = x.now_seconds;
    if (!x.climate_present || x.temp_invalid || rt < -2000 || rt > 8000 ||
        x.hum_invalid || rh < 0 || rh > 10000) begin
      error_held[0] = 1'b1;
    end else begin
      h = rh + p_hum_off;
      if (h < 0) h = 0;
      if (h > 10000) h = 10000;
      temp_held = rt + p_temp_off;
      hum_held = h;
      error_held[0] = 1'b0;
    end
    if (!x.power_present) begin
      error_held[1] = 1'b1;
    end else if (rv < 8000 || rv > 15000) begin
      volt_held = rv;
      amp_held = 0;
      watt_held = 0;
      error_held[1] = 1'b0;
    end else begin
      prod = rc * longint'(p_gain);
      amp = ((prod < 0 ? -prod : prod) + 128) >>> 8;
      if (amp > 12800) amp = 12800;
      if (prod < 0) amp = -amp;
      pw = rv * amp;
      watt = ((pw < 0 ? -pw : pw) + 500) / 1000;
      if (watt > 192000) watt = 192000;
      if (pw < 0) watt = -watt;
      volt_held = rv;
      amp_held = amp;
      watt_held = watt;
      error_held[1] = 1'b0;
      if (watt >= longint'(p_floor)) begin
        eff = peak_record;
        if (x.time_valid && peak_stamp > 0 && now > peak_stamp) begin
          eff = decayed_peak(now - peak_stamp);
          decays_seen++;
        end
        if (eff < p_floor) eff = p_floor;
        if (watt > longint'(eff)) begin
          peak_record = watt;
          peak_stamp = x.time_valid ? now : 0;
          eff = watt;
        end
        peak_shown = eff;
      end
    end
    r.temp_out = temp_held[14:0];
    r.hum_out = hum_held[13:0];
    r.volt_out = volt_held[14:0];
    r.amp_out = amp_held[14:0];
    r.watt_out = watt_held[18:0];
    r.peak_out = peak_shown[17:0];
    r.error_bits = error_held;
    return r;
  endfunction

  function automatic in_item_t reading(bit cp, bit pp, int rt, bit ti, int rh, bit hi,
                                       int rv, int rc, longint unsigned now, bit tv);
    in_item_t x;
    x.climate_present = cp;
    x.power_present = pp;
    x.raw_temp = 15'(rt);
    x.temp_invalid = ti;
    x.raw_hum = 15'(rh);
    x.hum_invalid = hi;
    x.raw_volt = 15'(rv);
    x.raw_current = 13'(rc);
    x.now_seconds = 32'(now);
    x.time_valid = tv;
    return x;
  endfunction

  function automatic out_item_t shown(int t, int h, int v, int a, int w, int pk, int e);
    out_item_t r;
    r.temp_out = 15'(t);
    r.hum_out = 14'(h);
    r.volt_out = 15'(v);
    r.amp_out = 15'(a);
    r.watt_out = 19'(w);
    r.peak_out = 18'(pk);
    r.error_bits = 2'(e);
    return r;
  endfunction

  function automatic in_item_t random_reading();
    in_item_t x;
    int       pick;
    pick = $urandom_range(0, 9);
    if (pick >= 8) begin
      x = reading($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
      return x;
    end
    case ($urandom_range(0, 5))
      0: wall = wall + $urandom_range(0, 100);
      1, 2: wall = wall + $urandom_range(0, 86400 * 20);
      3: wall = wall + $urandom_range(0, 86400 * 400);
      4: wall = wall + 64'($urandom) % (64'd86400 * 365 * 40);
      default: wall = wall;
    endcase
    wall = wall & 64'hFFFF_FFFF;
    x = reading($urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0,
                $urandom_range(0, 10000) - 2000, $urandom_range(0, 15) == 0,
                $urandom_range(0, 10000), $urandom_range(0, 15) == 0,
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767)
                                             : $urandom_range(8000, 15000),
                $urandom_range(0, 8191) - 4096, wall, $urandom_range(0, 7) != 0);
    return x;
  endfunction

  // watchdog, acceptance bookkeeping and result checking
  always @(posedge clk) begin
    out_item_t exp_r;
    note_t     n;
    if (rst) begin
      quiet <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", StallLimit);
        $display("RESULT: ERROR");
        $finish;
      end
      if (in_ch.valid && in_ch.ready) begin
        exp_r = qualify_reading(in_ch.data);
        n = typed_due.pop_front();
        readings_due.push_back(n.typed ? n.want : exp_r);
        taken_in <= taken_in + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        taken_out <= taken_out + 1;
        stall_left <= burst ? 0 : $urandom_range(0, 16);
        if (readings_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item %p", out_ch.data);
        end else begin
          exp_r = readings_due.pop_front();
          if (exp_r !== out_ch.data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch on item %0d: expected %p got %p",
                       taken_out, exp_r, out_ch.data);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = (stall_left == 0);
      if (stall_left > 0) stall_left = stall_left - 1;
    end
  end

  task automatic write_reg(reg_idx_t idx, longint value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = 18'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TEMP_OFFSET: p_temp_off = longint'($signed(cfg_data[10:0]));
      REG_HUM_OFFSET:  p_hum_off = longint'($signed(cfg_data[11:0]));
      REG_GAIN:        p_gain = cfg_data[10:0];
      REG_FLOOR:       p_floor = cfg_data;
      REG_HALFLIFE:    p_halflife = cfg_data[8:0];
      default: ;
    endcase
  endtask

  task automatic send_reading(in_item_t x, bit typed, out_item_t want);
    note_t n;
    int    gap;
    n.typed = typed;
    n.want = want;
    typed_due.push_back(n);
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = x;
    sent++;
    do @(negedge clk); while (taken_in < sent);
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (readings_due.size() != 0 || typed_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  initial begin
    row_t      rw;
    out_item_t none;
    longint    settings [5][6];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = REG_TEMP_OFFSET;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    stall_left = 0;
    burst = 1'b0;
    mismatches = 0;
    sent = 0;
    taken_in = 0;
    taken_out = 0;
    decays_seen = 0;
    wall = 0;
    none = '0;
    p_temp_off = 0;
    p_hum_off = 0;
    p_gain = 256;
    p_floor = 1000;
    p_halflife = 30;
    temp_held = 0;
    hum_held = 0;
    volt_held = 0;
    amp_held = 0;
    watt_held = 0;
    peak_record = 10000;
    peak_stamp = 0;
    peak_shown = 10000;
    error_held = 2'b00;

    // both sensors absent, after reset
    rw.item = reading(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    rw.typed = 1; rw.want = shown(0, 0, 0, 0, 0, 10000, 3); table_rows.push_back(rw);
    // climate low extremes, voltage just under window
    rw.item = reading(1, 1, -2000, 0, 0, 0, 7999, 3200, 10, 1);
    rw.typed = 1; rw.want = shown(-2000, 0, 7999, 0, 0, 10000, 0); table_rows.push_back(rw);
    // climate high extremes, new peak with timestamp
    rw.item = reading(1, 1, 8000, 0, 10000, 0, 8000, 3200, 1000, 1);
    rw.typed = 1; rw.want = shown(8000, 10000, 8000, 3200, 25600, 25600, 0);
    table_rows.push_back(rw);
    // temperature under range, negative power below floor
    rw.item = reading(1, 1, -2001, 0, 500, 0, 15000, -3200, 1100, 1);
    rw.typed = 1; rw.want = shown(8000, 10000, 15000, -3200, -48000, 25600, 1);
    table_rows.push_back(rw);
    rw.typed = 0; rw.want = none;
    rw.item = reading(1, 1, 100, 1, 500, 0, 15001, 3200, 1200, 1); table_rows.push_back(rw);
    rw.item = reading(1, 1, 100, 0, 500, 1, 32767, 3200, 1300, 1); table_rows.push_back(rw);
    rw.item = reading(1, 1, 8001, 0, 500, 0, 0, 3200, 1400, 1); table_rows.push_back(rw);
    rw.item = reading(1, 1, 100, 0, -1, 0, 12000, 0, 1500, 1); table_rows.push_back(rw);
    rw.item = reading(1, 1, 100, 0, 10001, 0, 12000, 50, 1600, 1); table_rows.push_back(rw);
    rw.item = reading(1, 0, -16384, 0, -16384, 0, 12000, 4095, 1700, 1);
    table_rows.push_back(rw);
    rw.item = reading(1, 1, 16383, 0, 16383, 0, 12000, -4096, 1800, 1);
    table_rows.push_back(rw);
    // one half-life later, decayed peak above this power
    rw.item = reading(1, 1, 2500, 0, 4000, 0, 12000, 100, 1000 + 86400 * 30, 1);
    table_rows.push_back(rw);
    // one and a half half-lives later, time not valid so no decay
    rw.item = reading(1, 1, 2500, 0, 4000, 0, 12000, 100, 1000 + 86400 * 45, 0);
    table_rows.push_back(rw);
    rw.item = reading(1, 1, 2500, 0, 4000, 0, 12000, 100, 1000 + 86400 * 45, 1);
    table_rows.push_back(rw);
    // new peak without valid time clears the timestamp
    rw.item = reading(1, 1, 2500, 0, 4000, 0, 14000, 3000, 5000, 0); table_rows.push_back(rw);
    rw.item = reading(1, 1, 2500, 0, 4000, 0, 14000, 100, 90000000, 1);
    table_rows.push_back(rw);
    // new timestamped peak, then time going back, then far future
    rw.item = reading(1, 1, 0, 0, 0, 0, 15000, 3200, 5000, 1); table_rows.push_back(rw);
    rw.item = reading(1, 1, 0, 0, 0, 0, 12000, 200, 4000, 1); table_rows.push_back(rw);
    rw.item = reading(1, 1, 0, 0, 0, 0, 12000, 200, 32'hFFFF_FFFF, 1); table_rows.push_back(rw);
    rw.item = reading(1, 1, 0, 0, 0, 0, 12000, 200, 5001, 1); table_rows.push_back(rw);

    settings[0] = '{0, 0, 256, 1000, 10000, 30};
    settings[1] = '{-1000, -2000, 0, 0, 0, 1};
    settings[2] = '{1000, 2000, 1024, 192000, 192000, 365};
    settings[3] = '{$urandom_range(0, 2000) - 1000, $urandom_range(0, 4000) - 2000,
                    $urandom_range(200, 1024), $urandom_range(0, 20000),
                    $urandom_range(0, 192000), $urandom_range(1, 365)};
    settings[4] = '{-37, 900, 700, 500, 1, 0};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (table_rows[i]) send_reading(table_rows[i].item, table_rows[i].typed,
                                         table_rows[i].want);
    drain_and_settle();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_TEMP_OFFSET, settings[ph][0]);
      write_reg(REG_HUM_OFFSET, settings[ph][1]);
      write_reg(REG_GAIN, settings[ph][2]);
      write_reg(REG_FLOOR, settings[ph][3]);
      write_reg(REG_INITIAL, settings[ph][4]);
      write_reg(REG_HALFLIFE, settings[ph][5]);
      for (int i = 0; i < 106; i++) begin
        if (i % 40 == 0) burst = ($urandom_range(0, 2) == 0);
        send_reading(random_reading(), 0, none);
      end
      burst = 1'b0;
      drain_and_settle();
    end

    $display("%0d readings sent, %0d results checked, %0d peak decays, 5 register sets",
             sent, taken_out, decays_seen);
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
